// ----- hdl/qrfp_pkg.sv -----
// Shared types and constants for the quote record field parser.
// No dependencies.
`timescale 1ns / 1ps
package qrfp_pkg;
  localparam int CODE_MAX = 16;
  localparam int NAME_MAX = 32;

  localparam logic [2:0] K_CODE  = 3'd0;
  localparam logic [2:0] K_NAME  = 3'd1;
  localparam logic [2:0] K_FIELD = 3'd2;
  localparam logic [2:0] K_END   = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;

  localparam logic [7:0] TAG_ID_MASK  = 8'hFC;
  localparam logic [7:0] TAG_LEN_MASK = 8'h03;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] market_type;
    logic [7:0]  record_index;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [5:0]  field_id;
    logic [31:0] field_value;
    logic        record_last;
    logic        message_last;
  } result_t;
endpackage

// ----- hdl/qrfp_front.sv -----
// Front end: accepts input bytes and runs the message parsing state machine.
// Depends on qrfp_pkg.
`timescale 1ns / 1ps
module qrfp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output logic             res_valid,
  output qrfp_pkg::result_t res
);
  import qrfp_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0, PH_HDR = 4'd1, PH_COUNT = 4'd2, PH_SIZE = 4'd3,
                         PH_FLAG = 4'd4, PH_CODELEN = 4'd5, PH_CODE = 4'd6,
                         PH_NAMELEN = 4'd7, PH_NAME = 4'd8, PH_TAG = 4'd9,
                         PH_VALUE = 4'd10;

  logic [3:0]  phase, phase_next;
  logic [31:0] header_shift, header_shift_next;
  logic [7:0]  records_left, records_left_next;
  logic [7:0]  record_size, record_size_next;
  logic [7:0]  record_offset, record_offset_next;
  logic        name_present, name_present_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [5:0]  current_field, current_field_next;
  logic [31:0] value_accum, value_accum_next;
  logic [7:0]  record_counter, record_counter_next;
  logic [7:0]  position_counter, position_counter_next;

  logic [8:0]  tag_end;
  logic [7:0]  bl_dec, off_inc;
  logic        have, closing, text_end;

  always_comb begin
    phase_next = phase;
    header_shift_next = header_shift;
    records_left_next = records_left;
    record_size_next = record_size;
    record_offset_next = record_offset;
    name_present_next = name_present;
    bytes_left_next = bytes_left;
    current_field_next = current_field;
    value_accum_next = value_accum;
    record_counter_next = record_counter;
    position_counter_next = position_counter;
    res_valid = 1'b0;
    res = '0;
    have = 1'b0;
    closing = 1'b0;
    bl_dec = bytes_left - 8'd1;
    off_inc = record_offset + 8'd1;
    tag_end = {1'b0, record_offset} + 9'd2 + {7'd0, data_byte[1:0]};
    text_end = 1'b0;
    res.market_type = header_shift;
    res.record_index = record_counter;

    if (first_byte) begin
      phase_next = PH_HDR;
      header_shift_next = {24'd0, data_byte};
      records_left_next = '0;
      record_size_next = '0;
      record_offset_next = '0;
      name_present_next = 1'b0;
      bytes_left_next = '0;
      current_field_next = '0;
      value_accum_next = '0;
      record_counter_next = '0;
      position_counter_next = 8'd1;
    end else begin
      unique case (phase)
        PH_HDR: begin
          header_shift_next = {header_shift[23:0], data_byte};
          position_counter_next = position_counter + 8'd1;
          if (position_counter_next >= 8'd4) phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (header_shift == '0) begin
            res_valid = 1'b1;
            res.kind = K_ERR;
            phase_next = PH_IDLE;
          end else begin
            records_left_next = data_byte;
            record_counter_next = '0;
            res.record_index = '0;
            if (data_byte == 8'd0) begin
              res_valid = 1'b1;
              res.kind = K_END;
              res.message_last = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          record_size_next = data_byte;
          record_offset_next = '0;
          phase_next = PH_FLAG;
        end
        PH_FLAG: begin
          name_present_next = (data_byte == 8'd1);
          record_offset_next = 8'd1;
          phase_next = PH_CODELEN;
        end
        PH_CODELEN, PH_NAMELEN: begin
          record_offset_next = off_inc;
          bytes_left_next = data_byte;
          position_counter_next = '0;
          if (data_byte != 8'd0) begin
            phase_next = (phase == PH_CODELEN) ? PH_CODE : PH_NAME;
          end else if (phase == PH_CODELEN && name_present) begin
            phase_next = PH_NAMELEN;
          end else if (off_inc < record_size) begin
            phase_next = PH_TAG;
          end else begin
            closing = 1'b1;
          end
        end
        PH_CODE, PH_NAME: begin
          if ({24'd0, position_counter} <
              ((phase == PH_CODE) ? 32'(CODE_MAX) : 32'(NAME_MAX))) begin
            have = 1'b1;
            res_valid = 1'b1;
            res.kind = (phase == PH_CODE) ? K_CODE : K_NAME;
            res.byte_index = position_counter;
            res.byte_value = data_byte;
          end
          position_counter_next = position_counter + 8'd1;
          record_offset_next = off_inc;
          bytes_left_next = bl_dec;
          text_end = (bl_dec == 8'd0);
          if (text_end) begin
            if (phase == PH_CODE && name_present) phase_next = PH_NAMELEN;
            else if (off_inc < record_size) phase_next = PH_TAG;
            else closing = 1'b1;
          end
        end
        PH_TAG: begin
          // The entry must fit: tag byte plus its value bytes.
          if (tag_end > {1'b0, record_size}) begin
            res_valid = 1'b1;
            res.kind = K_ERR;
            phase_next = PH_IDLE;
          end else begin
            current_field_next = 6'((data_byte & TAG_ID_MASK) >> 2);
            bytes_left_next = {6'd0, data_byte[1:0] & TAG_LEN_MASK[1:0]} + 8'd1;
            value_accum_next = '0;
            record_offset_next = off_inc;
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          value_accum_next = {value_accum[23:0], data_byte};
          record_offset_next = off_inc;
          bytes_left_next = bl_dec;
          if (bl_dec == 8'd0) begin
            have = 1'b1;
            res_valid = 1'b1;
            res.kind = K_FIELD;
            res.field_id = current_field;
            res.field_value = value_accum_next;
            if (off_inc < record_size) phase_next = PH_TAG;
            else closing = 1'b1;
          end
        end
        default: ;
      endcase
      if (closing) begin
        res_valid = 1'b1;
        if (!have) res.kind = K_END;
        res.record_last = 1'b1;
        records_left_next = records_left - 8'd1;
        record_counter_next = record_counter + 8'd1;
        if (records_left_next == 8'd0) begin
          res.message_last = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_SIZE;
        end
      end
    end
    if (!in_fire) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      header_shift <= '0;
      records_left <= '0;
      record_size <= '0;
      record_offset <= '0;
      name_present <= 1'b0;
      bytes_left <= '0;
      current_field <= '0;
      value_accum <= '0;
      record_counter <= '0;
      position_counter <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      header_shift <= header_shift_next;
      records_left <= records_left_next;
      record_size <= record_size_next;
      record_offset <= record_offset_next;
      name_present <= name_present_next;
      bytes_left <= bytes_left_next;
      current_field <= current_field_next;
      value_accum <= value_accum_next;
      record_counter <= record_counter_next;
      position_counter <= position_counter_next;
    end
  end
endmodule

// ----- hdl/qrfp_queue.sv -----
// Two-entry result queue between the parser and the output port.
// Depends on qrfp_pkg.
`timescale 1ns / 1ps
module qrfp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qrfp_pkg::result_t push_data,
  output logic              can_push,
  output logic              pop_valid,
  input  logic              pop,
  output qrfp_pkg::result_t pop_data
);
  import qrfp_pkg::*;

  result_t     mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign can_push  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hdl/quote_record_field_parser_top.sv -----
// Quote message parser: one byte per cycle in, one result per byte at most out.
// The parser state machine feeds a two-entry queue; ready is high while the
// queue has a free slot, so bytes flow every cycle unless the output stalls.
// Each result is written into the queue before it is presented at the output. Depends on qrfp_pkg.
`timescale 1ns / 1ps
module quote_record_field_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] market_type,
  output logic [7:0]  record_index,
  output logic [7:0]  byte_index,
  output logic [7:0]  byte_value,
  output logic [5:0]  field_id,
  output logic [31:0] field_value,
  output logic        record_last,
  output logic        message_last
);
  import qrfp_pkg::*;

  logic    in_fire, res_valid, can_push;
  result_t res, q_out;

  assign in_ready = can_push;
  assign in_fire  = in_valid && in_ready;

  qrfp_front u_front (
    .clk(clk), .rst(rst), .in_fire(in_fire), .data_byte(data_byte),
    .first_byte(first_byte), .res_valid(res_valid), .res(res)
  );

  qrfp_queue u_queue (
    .clk(clk), .rst(rst), .push(res_valid), .push_data(res), .can_push(can_push),
    .pop_valid(out_valid), .pop(out_valid && out_ready), .pop_data(q_out)
  );

  assign kind         = q_out.kind;
  assign market_type  = q_out.market_type;
  assign record_index = q_out.record_index;
  assign byte_index   = q_out.byte_index;
  assign byte_value   = q_out.byte_value;
  assign field_id     = q_out.field_id;
  assign field_value  = q_out.field_value;
  assign record_last  = q_out.record_last;
  assign message_last = q_out.message_last;

`ifndef NO_ASSERTIONS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind <= K_ERR)) else $error("bad kind");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !can_push |-> !in_ready) else $error("accept while full");
  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_last && kind != K_END && kind != K_ERR) |-> record_last)
    else $error("message end without record end");
`endif
endmodule
